/* src/mmd_pkg.sv */
// shared types and constants of the memory map decoder
`default_nettype none
package mmd_pkg;

  // number of watchpoints that take part in the compare
  localparam int unsigned WATCH_COUNT = 4;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 35;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_HI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FDD        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_BASE = 3'd3;

  // backing store geometry
  localparam int unsigned MEM_DEPTH = 65536;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned OFF_W     = 9;

  // memory map boundaries
  localparam logic [ADDR_W-1:0] ADDR_EXP_LO = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_EXP_HI = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_IO_RAM = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_PIO    = 16'hC800;
  localparam logic [ADDR_W-1:0] ADDR_CRTC   = 16'hCA00;
  localparam logic [ADDR_W-1:0] ADDR_FDD    = 16'hCC00;
  localparam logic [ADDR_W-1:0] ADDR_FDD_END = 16'hCD00;
  localparam logic [ADDR_W-1:0] ADDR_HI_RAM = 16'hD000;
  localparam logic [ADDR_W-1:0] ADDR_FDD_ROM = 16'hD800;
  localparam logic [ADDR_W-1:0] ADDR_ROM    = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_DRAM_TOP = 16'hBFFF;

  // parallel io mirrors every 32 bytes
  localparam int unsigned PIO_MIRROR = 32;
  localparam int unsigned PIO_OFF_W  = $clog2(PIO_MIRROR);

  // access opcodes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DEBUG = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  // decoded region codes
  typedef enum logic [2:0] {
    RGN_NONE = 3'd0,
    RGN_ROM  = 3'd1,
    RGN_RAM  = 3'd2,
    RGN_PIO  = 3'd3,
    RGN_CRTC = 3'd4,
    RGN_FDD  = 3'd5
  } region_e;

  // one watchpoint register, packed as written on the config port
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              range;
    logic [ADDR_W-1:0] stop_addr;
    logic [ADDR_W-1:0] start_addr;
  } watch_t;

  // result fields that wait for the memory read
  typedef struct packed {
    logic             rd_sel;
    region_e          region;
    logic [OFF_W-1:0] offset;
    logic             dev_wr;
    logic             dram;
    logic             hit;
  } res_t;

endpackage
`default_nettype wire

/* src/mmd_in_if.sv */
// input channel: one bus access per item
`default_nettype none
interface mmd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] bus_address;
  logic [7:0]  write_byte;

  modport source (output valid, opcode, bus_address, write_byte, input ready);
  modport sink   (input valid, opcode, bus_address, write_byte, output ready);
endinterface
`default_nettype wire

/* src/mmd_out_if.sv */
// output channel: one decode result per item
`default_nettype none
interface mmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [2:0] region_code;
  logic [8:0] device_offset;
  logic       device_write;
  logic       dram_access;
  logic       watch_hit;

  modport source (output valid, read_byte, region_code, device_offset, device_write,
                  dram_access, watch_hit, input ready);
  modport sink   (input valid, read_byte, region_code, device_offset, device_write,
                  dram_access, watch_hit, output ready);
endinterface
`default_nettype wire

/* src/mmd_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module mmd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

/* src/memory_map_decoder_with_watchpoints.sv */
// memory map decoder with a 64K byte backing ram and address watchpoints
//
//  channel   dir  handshake       contents
//  cfg       in   cfg_we_i        cfg_index_i, cfg_data_i (write only)
//  in_i      in   valid / ready   opcode, bus_address, write_byte
//  out_o     out  valid / ready   read_byte, region_code, device_offset,
//                                 device_write, dram_access, watch_hit
//
// an item is decoded and its ram access issued in the cycle it is accepted;
// the ram's registered read and the pending stage load at the accepting edge;
// the output register loads the result, and out_o.valid rises, when the
// pending stage advances into a free or draining output register.
// one item per cycle is sustained while out_o is drained.
// reset clears the mode bits and watchpoints; ram contents stay undefined.
// a stalled output holds the pending stage, which then holds in_i.ready low.
`default_nettype none
module memory_map_decoder_with_watchpoints (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mmd_in_if.sink                        in_i,
  mmd_out_if.source                     out_o
);
  import mmd_pkg::*;

  logic               ram_lo_q, ram_hi_q, fdd_q;
  watch_t             watch_q [WATCH_COUNT];

  op_e                op;
  logic [ADDR_W-1:0]  addr;
  region_e            region;
  logic [OFF_W-1:0]   offset;
  logic               is_dev;
  logic               rd_match, wr_match;
  logic               in_acc, advance;
  logic               ram_we, ram_re;
  logic [DATA_W-1:0]  ram_rdata;

  logic               s1_valid_q;
  res_t               s1_d, s1_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  rd_byte_q;
  res_t               out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_lo_q <= 1'b0;
      ram_hi_q <= 1'b0;
      fdd_q    <= 1'b0;
      for (int i = 0; i < WATCH_COUNT; i++) begin
        watch_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_RAM_LO) ram_lo_q <= cfg_data_i[0];
      if (cfg_index_i == CFG_RAM_HI) ram_hi_q <= cfg_data_i[0];
      if (cfg_index_i == CFG_FDD)    fdd_q    <= cfg_data_i[0];
      for (int i = 0; i < WATCH_COUNT; i++) begin
        if (cfg_index_i == CFG_WATCH_BASE + CFG_IDX_W'(i)) begin
          watch_q[i] <= watch_t'(cfg_data_i);
        end
      end
    end
  end

  assign op   = op_e'(in_i.opcode);
  assign addr = in_i.bus_address;

  // memory map decode
  always_comb begin
    offset = '0;
    if (addr < ADDR_EXP_LO) begin
      region = RGN_RAM;
    end else if (addr < ADDR_EXP_HI) begin
      region = (ram_lo_q || fdd_q) ? RGN_RAM : RGN_NONE;
    end else if (addr < ADDR_IO_RAM) begin
      region = (ram_hi_q || fdd_q) ? RGN_RAM : RGN_ROM;
    end else if (addr < ADDR_PIO) begin
      region = RGN_RAM;
    end else if (addr < ADDR_CRTC) begin
      region = RGN_PIO;
      offset = OFF_W'(addr[PIO_OFF_W-1:0]);
    end else if (addr < ADDR_FDD) begin
      region = RGN_CRTC;
      offset = OFF_W'(addr - ADDR_CRTC);
    end else if (addr < ADDR_FDD_END && fdd_q) begin
      region = RGN_FDD;
      offset = OFF_W'(addr - ADDR_FDD);
    end else if (addr < ADDR_HI_RAM) begin
      region = RGN_NONE;
    end else if (addr < ADDR_FDD_ROM) begin
      region = RGN_RAM;
    end else if (addr < ADDR_ROM) begin
      region = fdd_q ? RGN_ROM : RGN_NONE;
    end else begin
      region = RGN_ROM;
    end
  end

  assign is_dev = (region == RGN_PIO) || (region == RGN_CRTC) || (region == RGN_FDD);

  // watchpoint compare, one independent match per watchpoint
  always_comb begin
    logic match;
    rd_match = 1'b0;
    wr_match = 1'b0;
    for (int i = 0; i < WATCH_COUNT; i++) begin
      if (watch_q[i].range) begin
        match = (watch_q[i].start_addr <= addr) && (addr <= watch_q[i].stop_addr);
      end else begin
        match = (watch_q[i].start_addr == addr);
      end
      rd_match = rd_match | (match & watch_q[i].rd_en);
      wr_match = wr_match | (match & watch_q[i].wr_en);
    end
  end

  // handshake: pending stage moves on when the output register is free
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  // result fields and ram access per opcode
  always_comb begin
    s1_d        = '0;
    s1_d.region = region;
    s1_d.offset = offset;
    ram_we      = 1'b0;
    unique case (op)
      OP_READ: begin
        s1_d.rd_sel = (region == RGN_RAM) || (region == RGN_ROM);
        s1_d.dram   = (region == RGN_RAM) && (addr <= ADDR_DRAM_TOP);
        s1_d.hit    = rd_match;
      end
      OP_WRITE: begin
        ram_we      = in_acc && (region == RGN_RAM);
        s1_d.dram   = (region == RGN_RAM) && (addr <= ADDR_DRAM_TOP);
        s1_d.dev_wr = is_dev;
        s1_d.hit    = wr_match;
      end
      OP_DEBUG: begin
        s1_d.rd_sel = (region == RGN_RAM) || (region == RGN_ROM);
        s1_d.dram   = (region == RGN_RAM) && (addr <= ADDR_DRAM_TOP);
      end
      OP_LOAD: begin
        ram_we = in_acc;
      end
      default: begin
        s1_d = '0;
      end
    endcase
  end

  assign ram_re = in_acc && !ram_we;

  // backing store
  mmd_ram #(
    .Width (DATA_W),
    .Depth (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr),
    .wdata_i (in_i.write_byte),
    .rdata_o (ram_rdata)
  );

  // pending stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (advance) begin
      out_q     <= s1_q;
      rd_byte_q <= s1_q.rd_sel ? ram_rdata : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_byte     = rd_byte_q;
  assign out_o.region_code   = out_q.region;
  assign out_o.device_offset = out_q.offset;
  assign out_o.device_write  = out_q.dev_wr;
  assign out_o.dram_access   = out_q.dram;
  assign out_o.watch_hit     = out_q.hit;

endmodule
`default_nettype wire

/* test/memory_map_decoder_with_watchpoints_tb.sv */
// self-checking testbench of the memory map decoder with watchpoints
`timescale 1ns / 100ps
module memory_map_decoder_with_watchpoints_tb;
  import mmd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_ITEMS   = 200;
  localparam int unsigned ITEMS_PER_MAP  = 50;
  localparam int unsigned WATCH_REGS     = 4;

  // one decoded access as the block should report it
  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    region_e           region;
    logic [OFF_W-1:0]  offset;
    logic              dev_wr;
    logic              dram;
    logic              hit;
  } access_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mmd_in_if  in_ch();
  mmd_out_if out_ch();

  memory_map_decoder_with_watchpoints i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // mode bits and watchpoints as the block should hold them
  logic   map_ram_lo;
  logic   map_ram_hi;
  logic   map_fdd;
  watch_t watch_cfg [WATCH_REGS];

  // byte store image and the entries written so far
  logic [DATA_W-1:0] ram_image [MEM_DEPTH];
  bit                loaded    [MEM_DEPTH];
  logic [ADDR_W-1:0] loaded_pool [$];

  access_res_t expected_q [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned fail_count;
  int unsigned accesses_sent;
  int unsigned results_checked;
  int unsigned hits_seen;
  int unsigned cfg_writes;
  int unsigned map_settings;
  int unsigned quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // region and register offset of an address under the current mode bits
  function automatic region_e map_region(input logic [ADDR_W-1:0] a,
                                         output logic [OFF_W-1:0] off);
    off = '0;
    if (a < ADDR_EXP_LO) return RGN_RAM;
    if (a < ADDR_EXP_HI) return (map_ram_lo || map_fdd) ? RGN_RAM : RGN_NONE;
    if (a < ADDR_IO_RAM) return (map_ram_hi || map_fdd) ? RGN_RAM : RGN_ROM;
    if (a < ADDR_PIO) return RGN_RAM;
    if (a < ADDR_CRTC) begin
      off = OFF_W'((a - ADDR_PIO) % PIO_MIRROR);
      return RGN_PIO;
    end
    if (a < ADDR_FDD) begin
      off = OFF_W'(a - ADDR_CRTC);
      return RGN_CRTC;
    end
    if (a < ADDR_FDD_END && map_fdd) begin
      off = OFF_W'(a - ADDR_FDD);
      return RGN_FDD;
    end
    if (a < ADDR_HI_RAM) return RGN_NONE;
    if (a < ADDR_FDD_ROM) return RGN_RAM;
    if (a < ADDR_ROM) return map_fdd ? RGN_ROM : RGN_NONE;
    return RGN_ROM;
  endfunction

  // any enabled watchpoint matching the address
  function automatic logic watch_match(input logic [ADDR_W-1:0] a, input logic is_write);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < WATCH_COUNT && i < WATCH_REGS; i++) begin
      if (is_write ? watch_cfg[i].wr_en : watch_cfg[i].rd_en) begin
        if (watch_cfg[i].range)
          hit |= (watch_cfg[i].start_addr <= a) && (a <= watch_cfg[i].stop_addr);
        else
          hit |= (watch_cfg[i].start_addr == a);
      end
    end
    return hit;
  endfunction

  function automatic void store_byte(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] b);
    ram_image[a] = b;
    if (!loaded[a]) begin
      loaded[a] = 1'b1;
      loaded_pool.push_back(a);
    end
  endfunction

  // expected result of one access; updates the store image
  function automatic access_res_t predict_access(input op_e op, input logic [ADDR_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    access_res_t r;
    logic [OFF_W-1:0] off;
    r = '0;
    r.region = map_region(a, off);
    r.offset = off;
    if (op == OP_LOAD) begin
      store_byte(a, b);
      return r;
    end
    if (op != OP_DEBUG) r.hit = watch_match(a, op == OP_WRITE);
    r.dram = (r.region == RGN_RAM) && (a <= ADDR_DRAM_TOP);
    if (op == OP_WRITE) begin
      if (r.region == RGN_RAM) store_byte(a, b);
      r.dev_wr = r.region inside {RGN_PIO, RGN_CRTC, RGN_FDD};
    end else if (r.region inside {RGN_RAM, RGN_ROM}) begin
      r.read_byte = ram_image[a];
    end
    return r;
  endfunction

  function automatic string access_str(input access_res_t r);
    return $sformatf("rd=%02h rgn=%0d off=%03h dw=%b dram=%b hit=%b",
                     r.read_byte, r.region, r.offset, r.dev_wr, r.dram, r.hit);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // receiver: random backpressure
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // predict on each accepted access, check each accepted result, watchdog
  always @(posedge clk_i) begin : check_blk
    access_res_t got;
    access_res_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(predict_access(op_e'(in_ch.opcode), in_ch.bus_address,
                                            in_ch.write_byte));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.read_byte = out_ch.read_byte;
        got.region    = region_e'(out_ch.region_code);
        got.offset    = out_ch.device_offset;
        got.dev_wr    = out_ch.device_write;
        got.dram      = out_ch.dram_access;
        got.hit       = out_ch.watch_hit;
        results_checked++;
        if (got.hit === 1'b1) hits_seen++;
        if (expected_q.size() == 0) begin
          note_failure({"result with no access pending: ", access_str(got)});
        end else begin
          want = expected_q.pop_front();
          if (got.read_byte !== want.read_byte || got.region !== want.region ||
              got.offset !== want.offset || got.dev_wr !== want.dev_wr ||
              got.dram !== want.dram || got.hit !== want.hit)
            note_failure({"expected ", access_str(want), ", got ", access_str(got)});
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one configuration register write, mirrored into the prediction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_RAM_LO: map_ram_lo = data[0];
      CFG_RAM_HI: map_ram_hi = data[0];
      CFG_FDD:    map_fdd    = data[0];
      default: begin
        if (idx >= CFG_WATCH_BASE && idx < CFG_WATCH_BASE + WATCH_REGS)
          watch_cfg[idx - CFG_WATCH_BASE] = watch_t'(data);
      end
    endcase
    cfg_writes++;
  endtask

  task automatic write_map(input logic lo, input logic hi, input logic fdd);
    write_reg(CFG_RAM_LO, CFG_DATA_W'(lo));
    write_reg(CFG_RAM_HI, CFG_DATA_W'(hi));
    write_reg(CFG_FDD, CFG_DATA_W'(fdd));
  endtask

  function automatic watch_t make_watch(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop,
                                        input logic rng, input logic rd, input logic wr);
    watch_t w;
    w.start_addr = start;
    w.stop_addr  = stop;
    w.range      = rng;
    w.rd_en      = rd;
    w.wr_en      = wr;
    return w;
  endfunction

  // send one access; the sender may idle first
  task automatic send_access(input op_e op, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.bus_address <= a;
    in_ch.write_byte  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    accesses_sent++;
  endtask

  // stop sending and wait until every result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // an address close to one of the map boundaries
  function automatic logic [ADDR_W-1:0] near_boundary();
    logic [ADDR_W-1:0] bounds [12] = '{16'h0000, ADDR_EXP_LO, ADDR_EXP_HI, ADDR_IO_RAM,
                                       ADDR_PIO, ADDR_CRTC, ADDR_FDD, ADDR_FDD_END,
                                       ADDR_HI_RAM, ADDR_FDD_ROM, ADDR_ROM, 16'hFFFF};
    return bounds[$urandom_range(11)] + ADDR_W'($urandom_range(4)) - ADDR_W'(2);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address(input bit prefer_loaded);
    int unsigned pick;
    pick = $urandom_range(99);
    if (loaded_pool.size() != 0 && pick < (prefer_loaded ? 70 : 35))
      return loaded_pool[$urandom_range(loaded_pool.size() - 1)];
    if (pick < 80) return near_boundary();
    return ADDR_W'($urandom);
  endfunction

  function automatic watch_t random_watch();
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    start = pick_address(1'b1);
    stop  = ($urandom_range(3) == 0) ? pick_address(1'b0)
                                     : start + ADDR_W'($urandom_range(64));
    return make_watch(start, stop, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
  endfunction

  // new mode bits and watchpoints: all clear, all set, then random
  task automatic reprogram_map();
    watch_t w;
    if (map_settings == 0)      write_map(1'b0, 1'b0, 1'b0);
    else if (map_settings == 1) write_map(1'b1, 1'b1, 1'b1);
    else write_map(1'($urandom_range(1)), 1'($urandom_range(1)), ($urandom_range(2) == 0));
    for (int i = 0; i < WATCH_REGS; i++) begin
      if (map_settings == 0)      w = '0;
      else if (map_settings == 1) w = '1;
      else                        w = random_watch();
      write_reg(CFG_IDX_W'(CFG_WATCH_BASE + i), CFG_DATA_W'(w));
    end
    map_settings++;
  endtask

  // mostly loads, writes and reads of loaded entries; some noise on any address
  task automatic random_access();
    op_e               op;
    logic [ADDR_W-1:0] a;
    logic [OFF_W-1:0]  off;
    region_e           rgn;
    int unsigned       pick;
    pick = $urandom_range(99);
    op = (pick < 20) ? OP_LOAD : (pick < 45) ? OP_WRITE : (pick < 85) ? OP_READ : OP_DEBUG;
    a = pick_address(op inside {OP_READ, OP_DEBUG});
    rgn = map_region(a, off);
    // never read a store entry that was not written yet
    if (op inside {OP_READ, OP_DEBUG} && rgn inside {RGN_ROM, RGN_RAM} && !loaded[a])
      a = loaded_pool[$urandom_range(loaded_pool.size() - 1)];
    send_access(op, a, DATA_W'($urandom));
  endtask

  // reset map: loads, rom and ram reads, dropped rom write, peripheral windows
  task automatic test_default_map();
    send_access(OP_LOAD, 16'h0000, 8'h00);
    send_access(OP_LOAD, 16'hFFFF, 8'hFF);
    send_access(OP_LOAD, 16'hA000, 8'h5A);
    send_access(OP_LOAD, 16'hBFFF, 8'h3C);
    send_access(OP_LOAD, 16'hD800, 8'hC3);
    send_access(OP_LOAD, 16'h8000, 8'hA5);
    send_access(OP_READ, 16'h0000, 8'hFF);
    send_access(OP_READ, 16'hFFFF, 8'h00);
    send_access(OP_DEBUG, 16'hBFFF, 8'h00);
    send_access(OP_READ, 16'h8000, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'h11);
    send_access(OP_READ, 16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hC81F, 8'hEE);
    send_access(OP_READ, 16'hC9E5, 8'h00);
    send_access(OP_WRITE, 16'hCBFF, 8'h01);
    send_access(OP_READ, 16'hCC10, 8'h00);
    wait_drained();
  endtask

  // floppy map and the watchpoint cases: exact, write only, start past end, all set
  task automatic test_map_modes();
    write_map(1'b0, 1'b0, 1'b1);
    write_reg(CFG_WATCH_BASE, CFG_DATA_W'(make_watch(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1)));
    write_reg(CFG_IDX_W'(CFG_WATCH_BASE + 1),
              CFG_DATA_W'(make_watch(16'h7000, 16'h7FFF, 1'b1, 1'b0, 1'b1)));
    write_reg(CFG_IDX_W'(CFG_WATCH_BASE + 2),
              CFG_DATA_W'(make_watch(16'hB000, 16'h1000, 1'b1, 1'b1, 1'b1)));
    write_reg(CFG_IDX_W'(CFG_WATCH_BASE + 3), CFG_DATA_W'(make_watch('1, '1, 1'b1, 1'b1, 1'b1)));
    send_access(OP_READ, 16'hCC10, 8'h00);
    send_access(OP_WRITE, 16'hCCFF, 8'h01);
    send_access(OP_READ, 16'hD800, 8'h00);
    send_access(OP_WRITE, 16'h8000, 8'h77);
    send_access(OP_READ, 16'h8000, 8'h00);
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_DEBUG, 16'h0000, 8'h00);
    send_access(OP_WRITE, 16'h7FFF, 8'h81);
    send_access(OP_READ, 16'h7FFF, 8'h00);
    send_access(OP_READ, 16'hBFFF, 8'h00);
    send_access(OP_READ, 16'hFFFF, 8'h00);
    wait_drained();
  endtask

  // random traffic under one idle scheme, remapping after each drain
  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % ITEMS_PER_MAP == 0) begin
        wait_drained();
        reprogram_map();
      end
      random_access();
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_READ;
    in_ch.bus_address = '0;
    in_ch.write_byte  = '0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    rst_ni            = 1'b0;
    map_ram_lo        = 1'b0;
    map_ram_hi        = 1'b0;
    map_fdd           = 1'b0;
    for (int i = 0; i < WATCH_REGS; i++) watch_cfg[i] = '0;
    src_idle_pct = 29;
    snk_idle_pct = 80;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_map();
    test_map_modes();
    test_random_traffic(29, 80);
    test_random_traffic(80, 29);
    test_random_traffic(0, 0);
    wait_drained();

    if (expected_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_q.size()));
    $display("Run covered %0d accesses over %0d map settings (%0d register writes)",
             accesses_sent, map_settings + 2, cfg_writes);
    $display("%0d results checked, %0d watchpoint hits, %0d failures",
             results_checked, hits_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
